@@ design/gsbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbf_pkg: shared types, constants and functions of the gzip stored framer
// Holds the item kinds, byte positions of the framing sequence, the
// CRC-32 byte update and the fixed gzip header table.
// ----------------------------------------------------------------------------
package gsbf_pkg;

   // Operation codes of an input item.
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Kind of work that an accepted item turns into.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Largest payload of one stored block.
   localparam logic [31:0] MAX_BLOCK_BYTES = 32'd65535;
   localparam logic [15:0] MAX_BLOCK_LEN   = MAX_BLOCK_BYTES[15:0];

   // CRC-32 constants (reflected form).
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

   // Positions in the output byte sequence. The gzip header fills positions
   // zero through nine; a data byte or an error result takes position nine.
   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] POS_FIRST     = 5'd0;
   localparam logic [POS_W-1:0] POS_HDR_LAST  = 5'd9;
   localparam logic [POS_W-1:0] POS_BFINAL    = 5'd10;
   localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd11;
   localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd12;
   localparam logic [POS_W-1:0] POS_NLEN_LO   = 5'd13;
   localparam logic [POS_W-1:0] POS_BLK_LAST  = 5'd14;
   localparam logic [POS_W-1:0] POS_TRL_FIRST = 5'd15;
   localparam logic [POS_W-1:0] POS_CRC_B1    = 5'd16;
   localparam logic [POS_W-1:0] POS_CRC_B2    = 5'd17;
   localparam logic [POS_W-1:0] POS_CRC_B3    = 5'd18;
   localparam logic [POS_W-1:0] POS_SIZE_B0   = 5'd19;
   localparam logic [POS_W-1:0] POS_SIZE_B1   = 5'd20;
   localparam logic [POS_W-1:0] POS_SIZE_B2   = 5'd21;
   localparam logic [POS_W-1:0] POS_TRL_LAST  = 5'd22;

   // Everything the emitter needs to produce the bytes of one item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        blk_hdr;
      logic        bfinal;
      logic [15:0] chunk;
      logic        trailer;
      logic [31:0] crc;
      logic [31:0] size;
   } plan_type;

   // One byte of a reflected CRC-32 update.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Fixed gzip member header: magic, deflate, no flags, no time, unknown OS.
   function automatic logic [7:0] gz_header_byte(input logic [POS_W-1:0] pos);
      logic [7:0] b;
      case (pos)
         5'd0:    b = 8'h1f;
         5'd1:    b = 8'h8b;
         5'd2:    b = 8'h08;
         5'd9:    b = 8'hff;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ design/gzip_stored_block_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzip_stored_block_framer: gzip framing with stored DEFLATE blocks
// Turns a start item and a stream of payload byte items into a complete
// gzip stream: header, stored block headers, payload and CRC-32/ISIZE trailer.
// ----------------------------------------------------------------------------
// An accepted item is held as a plan; its bytes leave through the single
// output byte register. Throughput: one result byte per cycle while the
// result side does not stall. Bytes per item: data one, data ending a block
// six, data ending the message nine, start 15 (23 when empty).
// Reset is synchronous and active high; it closes any open message and
// presets the CRC. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
//
// Structure:
// The planning stage holds the message state (open flag, bytes left in the
// message and in the current block, message size and running CRC). When an
// item is accepted, it updates that state at once, including the eight-bit
// CRC step for a data byte, and hands a plan to the emitter: what kind of
// item it is, whether a block header or the trailer follows, and the values
// those bytes carry.
//
// The emitter keeps the plan of one item and walks a position counter over
// the byte sequence. Positions zero to nine are the gzip header; a data byte
// or an error result uses position nine alone. Positions ten to fourteen
// carry a block header and fifteen to twenty-two the trailer. Each byte goes
// into the result register, which a stall on the result side holds.
//
// The next item is taken in the same cycle in which the emitter issues the
// last byte of the current one, so a stream of payload items flows at one
// item per cycle while the result side keeps up.
module gzip_stored_block_framer
   import gsbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [31:0] req_message_length,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_stream,
   output logic        rsp_protocol_error
);

   plan_type plan;
   logic     busy;
   logic     accept;

   // The input side waits only while the held item still has bytes to go
   // after this cycle.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   gsbf_plan u_plan (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .operation      (req_operation),
      .message_length (req_message_length),
      .data_byte      (req_data_byte),
      .plan           (plan)
   );

   gsbf_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .plan               (plan),
      .busy_next          (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_stream  (rsp_end_of_stream),
      .rsp_protocol_error (rsp_protocol_error)
   );

endmodule

@@ design/gsbf_plan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbf_plan: message state and per-item planning
// Keeps the open message state, updates it when an item is accepted and
// builds the plan that tells the emitter which bytes the item produces.
// ----------------------------------------------------------------------------
module gsbf_plan
   import gsbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        operation,
   input  logic [31:0] message_length,
   input  logic [7:0]  data_byte,
   output plan_type    plan
);

   logic        open_ff,  open_in;
   logic [31:0] total_ff, total_in;
   logic [15:0] blk_ff,   blk_in;
   logic [31:0] size_ff,  size_in;
   logic [31:0] crc_ff,   crc_in;

   logic [31:0] crc_next;
   logic [31:0] total_dec;
   logic [15:0] blk_dec;
   logic [31:0] hdr_src;
   logic [15:0] chunk;
   logic        bfinal;

   assign crc_next  = crc_byte(crc_ff, data_byte);
   assign total_dec = total_ff - 32'd1;
   assign blk_dec   = blk_ff - 16'd1;

   // The next block header is sized from the bytes that remain.
   assign hdr_src = (operation == OP_START) ? message_length : total_dec;
   assign bfinal  = (hdr_src <= MAX_BLOCK_BYTES);
   assign chunk   = bfinal ? hdr_src[15:0] : MAX_BLOCK_LEN;

   always_comb begin
      open_in  = open_ff;
      total_in = total_ff;
      blk_in   = blk_ff;
      size_in  = size_ff;
      crc_in   = crc_ff;

      plan.kind      = KIND_ERROR;
      plan.data_byte = data_byte;
      plan.blk_hdr   = 1'b0;
      plan.bfinal    = bfinal;
      plan.chunk     = chunk;
      plan.trailer   = 1'b0;
      plan.crc       = ~crc_ff;
      plan.size      = size_ff;

      if (operation == OP_START) begin
         plan.kind    = KIND_START;
         plan.blk_hdr = 1'b1;
         plan.trailer = (message_length == 32'd0);
         plan.crc     = ~CRC_PRESET;
         plan.size    = message_length;
         open_in      = (message_length != 32'd0);
         total_in     = message_length;
         size_in      = message_length;
         crc_in       = CRC_PRESET;
         blk_in       = chunk;
      end else if (open_ff) begin
         plan.kind = KIND_DATA;
         plan.crc  = ~crc_next;
         crc_in    = crc_next;
         total_in  = total_dec;
         blk_in    = blk_dec;
         if (total_dec == 32'd0) begin
            plan.trailer = 1'b1;
            open_in      = 1'b0;
         end else if (blk_dec == 16'd0) begin
            plan.blk_hdr = 1'b1;
            blk_in       = chunk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         total_ff <= 32'd0;
         blk_ff   <= 16'd0;
         size_ff  <= 32'd0;
         crc_ff   <= CRC_PRESET;
      end else if (accept) begin
         open_ff  <= open_in;
         total_ff <= total_in;
         blk_ff   <= blk_in;
         size_ff  <= size_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

@@ design/gsbf_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbf_emit: byte sequencer and result register
// Holds the current item's plan, walks its byte positions one per cycle
// unless the result side stalls, and puts each byte in the result register.
// ----------------------------------------------------------------------------
module gsbf_emit
   import gsbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  plan_type   plan,
   output logic       busy_next,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_stream,
   output logic       rsp_protocol_error
);

   plan_type         cur_ff;
   logic             cur_valid_ff, cur_valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff, out_eos_ff, out_err_ff;

   logic             out_load;
   logic             cur_done;
   logic [POS_W-1:0] pos_end;
   logic [POS_W-1:0] pos_step;
   logic [7:0]       byte_sel;

   assign out_load = cur_valid_ff && (!out_valid_ff || !rsp_stall);

   always_comb begin
      if (cur_ff.trailer) begin
         pos_end = POS_TRL_LAST;
      end else if (cur_ff.blk_hdr) begin
         pos_end = POS_BLK_LAST;
      end else begin
         pos_end = POS_HDR_LAST;
      end
   end

   assign cur_done = out_load && (pos_ff == pos_end);
   // A new item may enter when nothing is held or the held one finishes now.
   assign busy_next = cur_valid_ff && !cur_done;

   // A data item that closes the message skips the block header positions.
   assign pos_step = (pos_ff == POS_HDR_LAST && !cur_ff.blk_hdr)
                     ? POS_TRL_FIRST : pos_ff + 5'd1;

   always_comb begin
      case (pos_ff)
         POS_HDR_LAST: begin
            if (cur_ff.kind == KIND_DATA) begin
               byte_sel = cur_ff.data_byte;
            end else if (cur_ff.kind == KIND_ERROR) begin
               byte_sel = 8'h00;
            end else begin
               byte_sel = gz_header_byte(pos_ff);
            end
         end
         POS_BFINAL:    byte_sel = {7'd0, cur_ff.bfinal};
         POS_LEN_LO:    byte_sel = cur_ff.chunk[7:0];
         POS_LEN_HI:    byte_sel = cur_ff.chunk[15:8];
         POS_NLEN_LO:   byte_sel = ~cur_ff.chunk[7:0];
         POS_BLK_LAST:  byte_sel = ~cur_ff.chunk[15:8];
         POS_TRL_FIRST: byte_sel = cur_ff.crc[7:0];
         POS_CRC_B1:    byte_sel = cur_ff.crc[15:8];
         POS_CRC_B2:    byte_sel = cur_ff.crc[23:16];
         POS_CRC_B3:    byte_sel = cur_ff.crc[31:24];
         POS_SIZE_B0:   byte_sel = cur_ff.size[7:0];
         POS_SIZE_B1:   byte_sel = cur_ff.size[15:8];
         POS_SIZE_B2:   byte_sel = cur_ff.size[23:16];
         POS_TRL_LAST:  byte_sel = cur_ff.size[31:24];
         default:       byte_sel = gz_header_byte(pos_ff);
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (accept) begin
         cur_valid_in = 1'b1;
         pos_in       = (plan.kind == KIND_START) ? POS_FIRST : POS_HDR_LAST;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (out_load) begin
         pos_in = pos_step;
      end
      out_valid_in = out_load ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_FIRST;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= plan;
      end
      if (out_load) begin
         out_byte_ff <= byte_sel;
         out_last_ff <= (pos_ff == pos_end);
         out_eos_ff  <= cur_ff.trailer && (pos_ff == POS_TRL_LAST);
         out_err_ff  <= (cur_ff.kind == KIND_ERROR);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_end_of_stream  = out_eos_ff;
   assign rsp_protocol_error = out_err_ff;

endmodule
